### hdl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared sizes, action and status codes, index helpers and the
// controller/datapath interface types of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ACT_W      = 3;
    localparam int STAT_W     = 2;
    localparam int WORD_W     = 32;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_OUT   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] elem_t;

    // controller to datapath
    typedef struct packed {
        logic take;   // latch the incoming word and read its slot
        logic exec;   // apply the latched action and load the result
        logic walk;   // emit the next read-out element
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;      // result register can take a new word
        logic readout_multi; // read-out with more than one element
        logic walk_last;     // element now emitted by the walk is the rear
    } stat_t;

    function automatic idx_t idx_next(input idx_t i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

    function automatic elem_t to_elem(input logic [WORD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'($signed(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input elem_t e);
        logic signed [63:0] w;
        w = 64'($signed(e));
        return w[WORD_W-1:0];
    endfunction

endpackage

### hdl/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the circular deque: takes one word, applies it, and walks
// the stored entries for a read-out.
// ----------------------------------------------------------------------------
module cdq_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cdq_pkg::stat_t stat,
    output cdq_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.readout_multi ? S_WALK : S_IDLE;
                end
            end
            S_WALK:
            begin
                if (stat.out_free)
                begin
                    cmd.walk = 1'b1;
                    if (stat.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/cdq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_datapath
// Slot memory, head/tail indices, fill count, read-out walker and the
// registered result word of the circular deque.
// ----------------------------------------------------------------------------
module cdq_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdq_pkg::cmd_t                 cmd,
    output cdq_pkg::stat_t                stat,
    input  logic [cdq_pkg::ACT_W-1:0]     s_tuser,
    input  logic [cdq_pkg::WORD_W-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdq_pkg::STAT_W-1:0]    m_tuser,
    output logic [cdq_pkg::WORD_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    cdq_pkg::elem_t mem [cdq_pkg::DEPTH];

    cdq_pkg::idx_t  head_reg, head_next;
    cdq_pkg::idx_t  tail_reg, tail_next;
    cdq_pkg::cnt_t  count_reg, count_next;
    cdq_pkg::cnt_t  left_reg, left_next;
    cdq_pkg::idx_t  rd_idx_reg;
    cdq_pkg::idx_t  rd_addr;
    cdq_pkg::idx_t  in_addr;
    cdq_pkg::elem_t rd_data_reg;

    logic [cdq_pkg::ACT_W-1:0]  act_reg;
    logic [cdq_pkg::WORD_W-1:0] val_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [cdq_pkg::STAT_W-1:0]  out_stat_reg, out_stat_next;
    logic [cdq_pkg::WORD_W-1:0]  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_load;

    logic                        wr_en;
    cdq_pkg::idx_t               wr_addr;

    logic full;
    logic empty;

    assign full  = (count_reg == cdq_pkg::CNT_W'(cdq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    // slot that the incoming action will read
    always_comb
    begin
        case (s_tuser)
            cdq_pkg::ACT_POP_REAR: in_addr = cdq_pkg::idx_prev(tail_reg);
            default:               in_addr = head_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.take)
        begin
            rd_addr = in_addr;
        end
        else if (cmd.exec || cmd.walk)
        begin
            rd_addr = cdq_pkg::idx_next(rd_idx_reg);
        end
        else
        begin
            rd_addr = rd_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= cdq_pkg::to_elem(val_reg);
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg <= s_tuser;
            val_reg <= s_tdata;
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        out_load       = 1'b0;
        out_stat_next  = cdq_pkg::ST_OK;
        out_data_next  = '0;
        out_last_next  = 1'b1;

        if (cmd.exec)
        begin
            case (act_reg)
                cdq_pkg::ACT_PUSH_FRONT,
                cdq_pkg::ACT_PUSH_REAR:
                begin
                    out_load = 1'b1;
                    if (full)
                    begin
                        out_stat_next = cdq_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = cdq_pkg::cnt_t'(count_reg + 1'b1);
                        if (act_reg == cdq_pkg::ACT_PUSH_FRONT)
                        begin
                            head_next = cdq_pkg::idx_prev(head_reg);
                            wr_addr   = cdq_pkg::idx_prev(head_reg);
                        end
                        else
                        begin
                            tail_next = cdq_pkg::idx_next(tail_reg);
                        end
                    end
                end
                cdq_pkg::ACT_POP_FRONT,
                cdq_pkg::ACT_POP_REAR:
                begin
                    out_load = 1'b1;
                    if (empty)
                    begin
                        out_stat_next = cdq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        out_data_next = cdq_pkg::to_word(rd_data_reg);
                        count_next    = cdq_pkg::cnt_t'(count_reg - 1'b1);
                        if (act_reg == cdq_pkg::ACT_POP_FRONT)
                        begin
                            head_next = cdq_pkg::idx_next(head_reg);
                        end
                        else
                        begin
                            tail_next = cdq_pkg::idx_prev(tail_reg);
                        end
                    end
                end
                cdq_pkg::ACT_READ_OUT:
                begin
                    out_load = 1'b1;
                    if (empty)
                    begin
                        out_stat_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        out_data_next = cdq_pkg::to_word(rd_data_reg);
                        out_last_next = (count_reg == cdq_pkg::CNT_W'(1));
                        left_next     = cdq_pkg::cnt_t'(count_reg - 1'b1);
                    end
                end
                default:
                begin
                    // unused codes give no result
                    out_load = 1'b0;
                end
            endcase
        end
        else if (cmd.walk)
        begin
            out_load      = 1'b1;
            out_data_next = cdq_pkg::to_word(rd_data_reg);
            out_last_next = (left_reg == cdq_pkg::CNT_W'(1));
            left_next     = cdq_pkg::cnt_t'(left_reg - 1'b1);
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            rd_idx_reg    <= rd_addr;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_stat_reg <= out_stat_next;
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign stat.out_free      = !out_valid_reg || m_tready;
    assign stat.readout_multi = (act_reg == cdq_pkg::ACT_READ_OUT)
                                && (count_reg > cdq_pkg::CNT_W'(1));
    assign stat.walk_last     = (left_reg == cdq_pkg::CNT_W'(1));

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hdl/circular_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_top
// Double-ended queue in a circular slot buffer with push/pop at both ends
// and a front-to-rear read-out of the whole contents.
// ----------------------------------------------------------------------------
// the accepted word is latched with its slot read, then applied once the
// result register is free, which loads the registered result word; no new
// word is taken until the last is applied and any read-out is through; a
// read-out walks from the front, one slot memory read per cycle while the result register is free
// reset clears head, tail and fill count at once; slot contents are not reset
// ----------------------------------------------------------------------------
module circular_deque_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [cdq_pkg::ACT_W-1:0]  s_tuser,   // [2:0] action
    input  logic [cdq_pkg::WORD_W-1:0] s_tdata,   // [31:0] value
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [cdq_pkg::STAT_W-1:0] m_tuser,   // [1:0] status
    output logic [cdq_pkg::WORD_W-1:0] m_tdata,   // [31:0] data
    output logic                       m_tlast
);

    cdq_pkg::cmd_t  cmd;
    cdq_pkg::stat_t stat;

    cdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdq_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### hdl/cdq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [cdq_pkg::STAT_W-1:0] m_tuser,
    input logic [cdq_pkg::WORD_W-1:0] m_tdata,
    input logic                       m_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // error and empty results stand alone
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cdq_pkg::ST_OK |-> m_tlast)
        else $error("non-ok result not marked last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == cdq_pkg::ST_OVERFLOW
            || m_tuser == cdq_pkg::ST_UNDERFLOW
            || m_tuser == cdq_pkg::ST_EMPTY) |-> m_tdata == '0)
        else $error("non-ok result carries data");

    // one word in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous word still in work");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/tb_circular_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_deque_top
// Self-checking bench for the circular deque: a shadow deque predicts every
// result word of pushes, pops and read-outs, and a scoreboard compares the
// status, data and last fields in order under random source/sink idling.
// ----------------------------------------------------------------------------
module tb_circular_deque_top;

    import cdq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 35;

    // codes the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] data;
        logic              last;
    } deque_result_t;

    class deque_scoreboard;
        elem_t         slot_mem[DEPTH];
        int            head;
        int            tail;
        int            fill;
        deque_result_t expected_q[$];
        int            errors;
        int            words_in;
        int            words_out;
        int            readout_words;
        int            n_overflow;
        int            n_underflow;
        int            n_empty;
        int            peak_fill;

        function new();
            head          = 0;
            tail          = 0;
            fill          = 0;
            errors        = 0;
            words_in      = 0;
            words_out     = 0;
            readout_words = 0;
            n_overflow    = 0;
            n_underflow   = 0;
            n_empty       = 0;
            peak_fill     = 0;
        endfunction

        function void add_result(logic [STAT_W-1:0] status, logic [WORD_W-1:0] data,
                                 logic last);
            deque_result_t r;
            r.status = status;
            r.data   = data;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // stored element sign-extended to the word width
        function logic [WORD_W-1:0] elem_word(elem_t e);
            logic signed [63:0] wide;
            wide = 64'($signed(e));
            return wide[WORD_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // accepted input word: advance the shadow deque and queue its results
        function void note_word(logic [ACT_W-1:0] action, logic [WORD_W-1:0] value);
            logic signed [63:0] wide;
            elem_t              e;
            int                 idx;
            words_in++;
            case (action)
                ACT_PUSH_FRONT, ACT_PUSH_REAR:
                begin
                    if (fill == DEPTH)
                    begin
                        add_result(ST_OVERFLOW, '0, 1'b1);
                        n_overflow++;
                    end
                    else
                    begin
                        wide = 64'($signed(value));
                        e    = wide[DATA_WIDTH-1:0];
                        if (action == ACT_PUSH_FRONT)
                        begin
                            head           = (head == 0) ? DEPTH - 1 : head - 1;
                            slot_mem[head] = e;
                        end
                        else
                        begin
                            slot_mem[tail] = e;
                            tail           = (tail == DEPTH - 1) ? 0 : tail + 1;
                        end
                        fill++;
                        if (fill > peak_fill)
                            peak_fill = fill;
                        add_result(ST_OK, '0, 1'b1);
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR:
                begin
                    if (fill == 0)
                    begin
                        add_result(ST_UNDERFLOW, '0, 1'b1);
                        n_underflow++;
                    end
                    else
                    begin
                        if (action == ACT_POP_FRONT)
                        begin
                            e    = slot_mem[head];
                            head = (head == DEPTH - 1) ? 0 : head + 1;
                        end
                        else
                        begin
                            tail = (tail == 0) ? DEPTH - 1 : tail - 1;
                            e    = slot_mem[tail];
                        end
                        fill--;
                        add_result(ST_OK, elem_word(e), 1'b1);
                    end
                end
                ACT_READ_OUT:
                begin
                    if (fill == 0)
                    begin
                        add_result(ST_EMPTY, '0, 1'b1);
                        n_empty++;
                    end
                    else
                    begin
                        idx = head;
                        for (int k = 0; k < fill; k++)
                        begin
                            add_result(ST_OK, elem_word(slot_mem[idx]), k == fill - 1);
                            idx = (idx == DEPTH - 1) ? 0 : idx + 1;
                            readout_words++;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [STAT_W-1:0] status, logic [WORD_W-1:0] data,
                                 logic last);
            deque_result_t exp_r;
            words_out++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: status %0d data %h last %0b",
                       status, data, last);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, status);
                errors++;
            end
            if (data !== exp_r.data)
            begin
                $error("data: expected %h, got %h", exp_r.data, data);
                errors++;
            end
            if (last !== exp_r.last)
            begin
                $error("last: expected %0b, got %0b", exp_r.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ACT_W-1:0]  s_tuser  = '0;   // [2:0] action
    logic [WORD_W-1:0] s_tdata  = '0;   // [31:0] value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [STAT_W-1:0] m_tuser;         // [1:0] status
    logic [WORD_W-1:0] m_tdata;         // [31:0] data
    logic              m_tlast;

    int              idle_pct  = 0;
    int              stall_pct = 0;
    int              cycles    = 0;
    deque_scoreboard sb;

    circular_deque_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("circular_deque_top verification failed");
            $finish;
        end
    end

    // present one word and hold it until the block takes it
    task send_word(logic [ACT_W-1:0] action, logic [WORD_W-1:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tuser  <= ACT_W'($urandom);
            s_tdata  <= $urandom;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function logic [WORD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // fill-heavy and drain-heavy bursts so full and empty are both reached often
    task random_items(int count);
        int               done;
        int               push_pct;
        int               r;
        logic [ACT_W-1:0] action;
        done     = 0;
        push_pct = 50;
        while (done < count)
        begin
            if (done % 10 == 0)
                push_pct = $urandom_range(1) ? 75 : 25;
            r = $urandom_range(99);
            if (r < 8)
                action = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            else if (r < 20)
                action = ACT_READ_OUT;
            else if ($urandom_range(99) < push_pct)
                action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            else
                action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
            send_word(action, pick_value());
            if (action <= ACT_READ_OUT)
                done++;
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme values at both ends, pop down to empty
        send_word(ACT_PUSH_REAR, 32'h7fff_ffff);
        send_word(ACT_PUSH_FRONT, 32'h8000_0000);
        send_word(ACT_PUSH_REAR, 32'h0000_0000);
        send_word(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_word(ACT_READ_OUT, 32'h0);
        send_word(ACT_POP_FRONT, 32'h0);
        send_word(ACT_POP_REAR, 32'h0);
        send_word(ACT_POP_FRONT, 32'h0);
        send_word(ACT_POP_REAR, 32'h0);
        // empty deque: underflow on both pops, empty read-out
        send_word(ACT_POP_FRONT, 32'h0);
        send_word(ACT_POP_REAR, 32'h0);
        send_word(ACT_READ_OUT, 32'h0);
        for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++)
            send_word(a[ACT_W-1:0], $urandom);
        // fill to capacity from both ends, then overflow and full read-out
        for (int i = 0; i < DEPTH; i++)
            send_word((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_value());
        send_word(ACT_PUSH_FRONT, pick_value());
        send_word(ACT_PUSH_REAR, pick_value());
        send_word(ACT_READ_OUT, 32'h0);

        idle_pct  = 0;
        stall_pct = 0;
        random_items(PHASE_ITEMS);
        idle_pct  = 58;
        stall_pct = 0;
        random_items(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 58;
        random_items(PHASE_ITEMS);
        idle_pct  = 11;
        stall_pct = 11;
        random_items(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        $display("run covered %0d input words and %0d result words (%0d from read-outs)",
                 sb.words_in, sb.words_out, sb.readout_words);
        $display("overflows %0d, underflows %0d, empty read-outs %0d, peak fill %0d",
                 sb.n_overflow, sb.n_underflow, sb.n_empty, sb.peak_fill);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("circular_deque_top verification clean");
        else
            $display("circular_deque_top verification failed");
        $finish;
    end

endmodule

### filelist.f
hdl/cdq_pkg.sv
hdl/cdq_ctrl.sv
hdl/cdq_datapath.sv
hdl/circular_deque_top.sv
hdl/cdq_checker.sv
bench/tb_circular_deque_top.sv
